### rtl/core/pu2k_pkg.sv
// Shared types and codes for the keyed 2x pixel upscaler.
// No dependencies.
`default_nettype none

package pu2k_pkg;

    // Per-window control that travels with the data through the pipeline.
    typedef struct packed {
        logic is_key;   // center pixel matches the color key
        logic use_r;    // right neighbor counts
        logic use_b;    // below neighbor counts
        logic use_d;    // diagonal neighbor counts
    } pu2k_ctl_t;

    // Number of counting pixels minus one, selects the bottom-right divisor.
    typedef logic [1:0] pu2k_cnt_t;
    localparam pu2k_cnt_t CNT_ONE   = 2'd0;
    localparam pu2k_cnt_t CNT_TWO   = 2'd1;
    localparam pu2k_cnt_t CNT_THREE = 2'd2;
    localparam pu2k_cnt_t CNT_FOUR  = 2'd3;

    // Register indexes of the configuration port.
    localparam logic REG_KEY_COLOR = 1'b0;

endpackage

`default_nettype wire

### rtl/core/pu2k_lane.sv
// One color channel of the upscaler: averages, divide, key select.
// Three register stages; depends on pu2k_pkg.
`default_nettype none

module pu2k_lane #(
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                    aclk,
    input  wire logic                    en,
    input  wire pu2k_pkg::pu2k_ctl_t     ctl,
    input  wire logic [CHANNEL_BITS-1:0] c_chan,
    input  wire logic [CHANNEL_BITS-1:0] r_chan,
    input  wire logic [CHANNEL_BITS-1:0] b_chan,
    input  wire logic [CHANNEL_BITS-1:0] d_chan,
    input  wire logic [CHANNEL_BITS-1:0] key_chan,
    output logic      [CHANNEL_BITS-1:0] tl_chan,
    output logic      [CHANNEL_BITS-1:0] tr_chan,
    output logic      [CHANNEL_BITS-1:0] bl_chan,
    output logic      [CHANNEL_BITS-1:0] br_chan
);
    import pu2k_pkg::*;

    localparam int CB = CHANNEL_BITS;
    localparam int SW = CB + 2;                    // sum of up to four channels
    // floor(2^SW / 3): estimate is exact or one low for every sum below 2^SW
    localparam logic [SW-1:0] RECIP3 = SW'((2 ** SW) / 3);

    // stage C: sums
    logic [CB-1:0] c_tl_reg, c_tr_reg, c_bl_reg;
    logic [SW-1:0] c_sum_reg;
    pu2k_cnt_t     c_cnt_reg;
    logic          c_key_reg;

    logic [CB:0]   pair_r, pair_b;
    logic [SW-1:0] sum_next;
    pu2k_cnt_t     cnt_next;

    always_comb begin
        pair_r   = {1'b0, c_chan} + {1'b0, r_chan};
        pair_b   = {1'b0, c_chan} + {1'b0, b_chan};
        sum_next = SW'(c_chan)
                 + (ctl.use_r ? SW'(r_chan) : '0)
                 + (ctl.use_b ? SW'(b_chan) : '0)
                 + (ctl.use_d ? SW'(d_chan) : '0);
        cnt_next = pu2k_cnt_t'(ctl.use_r) + pu2k_cnt_t'(ctl.use_b)
                 + pu2k_cnt_t'(ctl.use_d);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_tl_reg  <= c_chan;
            c_tr_reg  <= ctl.use_r ? pair_r[CB:1] : c_chan;
            c_bl_reg  <= ctl.use_b ? pair_b[CB:1] : c_chan;
            c_sum_reg <= sum_next;
            c_cnt_reg <= cnt_next;
            c_key_reg <= ctl.is_key;
        end
    end

    // stage D: quotient estimate
    logic [CB-1:0] d_tl_reg, d_tr_reg, d_bl_reg;
    logic [SW-1:0] d_sum_reg, d_q_reg;
    logic          d_div3_reg, d_key_reg;

    logic [2*SW-1:0] prod3;
    logic [SW-1:0]   q_next;

    always_comb begin
        prod3 = c_sum_reg * RECIP3;
        case (c_cnt_reg)
            CNT_ONE:   q_next = c_sum_reg;
            CNT_TWO:   q_next = c_sum_reg >> 1;
            CNT_THREE: q_next = prod3[2*SW-1:SW];
            CNT_FOUR:  q_next = c_sum_reg >> 2;
            default:   q_next = c_sum_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_tl_reg   <= c_tl_reg;
            d_tr_reg   <= c_tr_reg;
            d_bl_reg   <= c_bl_reg;
            d_sum_reg  <= c_sum_reg;
            d_q_reg    <= q_next;
            d_div3_reg <= (c_cnt_reg == CNT_THREE);
            d_key_reg  <= c_key_reg;
        end
    end

    // stage E: divide-by-three correction and key select
    logic [SW+1:0] rem3;
    logic [SW-1:0] q_fix;

    always_comb begin
        rem3  = {2'b00, d_sum_reg} - ({2'b00, d_q_reg} + {1'b0, d_q_reg, 1'b0});
        q_fix = (d_div3_reg && rem3 >= (SW+2)'(3)) ? d_q_reg + SW'(1) : d_q_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tl_chan <= d_key_reg ? key_chan : d_tl_reg;
            tr_chan <= d_key_reg ? key_chan : d_tr_reg;
            bl_chan <= d_key_reg ? key_chan : d_bl_reg;
            br_chan <= d_key_reg ? key_chan : q_fix[CB-1:0];
        end
    end

endmodule

`default_nettype wire

### rtl/core/pixel_upscale_2x_keyed_core.sv
// Top level of the keyed 2x pixel upscaler: stream ports, key register,
// key compare stage and three channel lanes. Depends on pu2k_pkg, pu2k_lane.
`default_nettype none

// Usage
//   s_ channel: one word per source pixel, carrying its 2x2 window (center,
//   right, below, diagonal) in s_tdata and the two range flags in s_tuser.
//   m_ channel: one word per source pixel with the four output pixels of
//   the doubled image.
//   APB port: key_color at byte address 0; write it only while the
//   pipeline is empty.
// Timing
//   Five register stages: input capture, key compare, channel sums,
//   quotient estimate, correction/output. One word per clock sustained
//   while m_tready is high; the rate is set by the single shared pipeline
//   enable, and every stage advances whenever that enable is high.
//   The bottom-right divide by three is a reciprocal multiply followed by
//   a one-step correction in the next stage.
// Reset
//   aresetn low clears all valid bits and sets the key to zero.
// Stall
//   When m_tready is low with a word waiting, the whole pipeline freezes
//   and s_tready drops; nothing is dropped or repeated. Empty stages do not
//   hold it up: s_tready stays high while the output register is free.
module pixel_upscale_2x_keyed_core #(
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    // s_tdata: center, right, below, diagonal pixel, zero padded to bytes
    input  wire logic [((12*CHANNEL_BITS+7)/8)*8-1:0]      s_tdata,
    // s_tuser: right_in_range, below_in_range
    input  wire logic [1:0]                                s_tuser,
    input  wire logic                                      s_tvalid,
    output logic                                           s_tready,
    // m_tdata: top left, top right, bottom left, bottom right, zero padded
    output logic      [((12*CHANNEL_BITS+7)/8)*8-1:0]      m_tdata,
    output logic                                           m_tvalid,
    input  wire logic                                      m_tready,
    input  wire logic                                      psel,
    input  wire logic                                      penable,
    input  wire logic                                      pwrite,
    input  wire logic [((3*CHANNEL_BITS > 32) ? 4 : 3)-1:0] paddr,
    input  wire logic [((3*CHANNEL_BITS > 32) ? 64 : 32)-1:0] pwdata,
    output logic      [((3*CHANNEL_BITS > 32) ? 64 : 32)-1:0] prdata,
    output logic                                           pready
);
    import pu2k_pkg::*;

    localparam int CB      = CHANNEL_BITS;
    localparam int PIX_W   = 3 * CB;
    localparam int WIN_W   = 4 * PIX_W;
    localparam int TDATA_W = ((WIN_W + 7) / 8) * 8;
    localparam int DATA_W  = (PIX_W > 32) ? 64 : 32;
    localparam int ADDR_W  = (PIX_W > 32) ? 4 : 3;

    // ---------------- configuration ----------------
    logic [PIX_W-1:0] key_reg;
    logic             reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[ADDR_W-1];
    assign prdata    = (reg_index == REG_KEY_COLOR) ? DATA_W'(key_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (psel && penable && pwrite && reg_index == REG_KEY_COLOR) begin
            key_reg <= pwdata[PIX_W-1:0];
        end
    end

    // ---------------- pipeline control ----------------
    // Valid bits for capture, compare, sums, estimate and output stages.
    logic [4:0] valid_reg;
    logic       en;

    assign en       = !valid_reg[4] || m_tready;
    assign s_tready = en;
    assign m_tvalid = valid_reg[4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[3:0], s_tvalid};
        end
    end

    // ---------------- stage A: capture ----------------
    logic [WIN_W-1:0] a_win_reg;
    logic             a_rin_reg, a_bin_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            a_win_reg <= s_tdata[WIN_W-1:0];
            a_rin_reg <= s_tuser[0];
            a_bin_reg <= s_tuser[1];
        end
    end

    // ---------------- stage B: key compare ----------------
    logic [PIX_W-1:0] a_c, a_r, a_b, a_d;
    pu2k_ctl_t        ctl_next;

    assign a_c = a_win_reg[0*PIX_W +: PIX_W];
    assign a_r = a_win_reg[1*PIX_W +: PIX_W];
    assign a_b = a_win_reg[2*PIX_W +: PIX_W];
    assign a_d = a_win_reg[3*PIX_W +: PIX_W];

    always_comb begin
        ctl_next.is_key = (a_c == key_reg);
        ctl_next.use_r  = a_rin_reg && (a_r != key_reg);
        ctl_next.use_b  = a_bin_reg && (a_b != key_reg);
        ctl_next.use_d  = a_rin_reg && a_bin_reg && (a_d != key_reg);
    end

    logic [WIN_W-1:0] b_win_reg;
    pu2k_ctl_t        b_ctl_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            b_win_reg <= a_win_reg;
            b_ctl_reg <= ctl_next;
        end
    end

    // ---------------- stages C to E: per-channel lanes ----------------
    logic [PIX_W-1:0] tl_pix, tr_pix, bl_pix, br_pix;

    for (genvar k = 0; k < 3; k++) begin : g_lane
        pu2k_lane #(
            .CHANNEL_BITS(CB)
        ) u_lane (
            .aclk     (aclk),
            .en       (en),
            .ctl      (b_ctl_reg),
            .c_chan   (b_win_reg[0*PIX_W + k*CB +: CB]),
            .r_chan   (b_win_reg[1*PIX_W + k*CB +: CB]),
            .b_chan   (b_win_reg[2*PIX_W + k*CB +: CB]),
            .d_chan   (b_win_reg[3*PIX_W + k*CB +: CB]),
            .key_chan (key_reg[k*CB +: CB]),
            .tl_chan  (tl_pix[k*CB +: CB]),
            .tr_chan  (tr_pix[k*CB +: CB]),
            .bl_chan  (bl_pix[k*CB +: CB]),
            .br_chan  (br_pix[k*CB +: CB])
        );
    end

    assign m_tdata = TDATA_W'({br_pix, bl_pix, tr_pix, tl_pix});

endmodule

`default_nettype wire
